// ===== rtl/core/i2crf_pkg.sv =====
// Shared types, codes and helpers for the I2C target register file.
`timescale 1ns / 1ps

package i2crf_pkg;

    localparam int NUM_REGS_DEF  = 256;
    localparam int FLAG_BITS_DEF = 32;
    localparam int CFG_DATA_W    = 9;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [15:0] BYTE_MASK     = 16'h00ff;
    localparam logic [8:0]  REG_COUNT_RST = 9'd256;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REG_SIZE  = 2'd0,
        CFG_ADDR_SIZE = 2'd1,
        CFG_REG_COUNT = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        MODE_BUS_WRITE   = 3'd0,
        MODE_BUS_READ    = 3'd1,
        MODE_LOCAL_READ  = 3'd2,
        MODE_LOCAL_WRITE = 3'd3,
        MODE_POP_FLAG    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_RANGE   = 2'd1,
        ST_IGNORED = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]  mode;
        logic [3:0]  byte_count;
        logic [15:0] reg_address;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        flag_found;
        logic [4:0]  flag_index;
        logic [1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [1:0] reg_size_code;
        logic       addr_size_code;
        logic [8:0] reg_count;
    } t_cfg;

    // Decoded access for one transaction in the first stage
    typedef struct packed {
        logic        ram_we;
        logic        ram_re;
        logic [15:0] ram_addr;
        logic [31:0] ram_wdata;
        logic        flag_found;
        logic [4:0]  flag_index;
        t_status     status;
    } t_access;

    function automatic logic [31:0] f_width_mask(input logic [1:0] size_code);
        logic [31:0] m;
        case (size_code)
            2'd0:    m = 32'h0000_00ff;
            2'd1:    m = 32'h0000_ffff;
            default: m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    function automatic logic [3:0] f_reg_bytes(input logic [1:0] size_code);
        logic [3:0] n;
        case (size_code)
            2'd0:    n = 4'd1;
            2'd1:    n = 4'd2;
            default: n = 4'd4;
        endcase
        return n;
    endfunction

endpackage

// ===== rtl/core/i2crf_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps

module i2crf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic             i_re,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/i2crf_access.sv =====
// Transaction decode, read pointer and written flags of the register file.
`timescale 1ns / 1ps

module i2crf_access #(
    parameter int NUM_REGS  = i2crf_pkg::NUM_REGS_DEF,
    parameter int FLAG_BITS = i2crf_pkg::FLAG_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2crf_pkg::t_cfg     i_cfg,
    input  i2crf_pkg::t_in_item i_item,
    input  logic                i_commit,
    output i2crf_pkg::t_access  o_acc
);

    import i2crf_pkg::*;

    logic [15:0]          r_ptr;
    logic [15:0]          n_ptr;
    logic [FLAG_BITS-1:0] r_flags;
    logic [FLAG_BITS-1:0] n_flags;

    logic [3:0]           w_abytes;
    logic [3:0]           w_rbytes;
    logic [31:0]          w_mask;
    logic [15:0]          w_baddr;
    logic [FLAG_BITS-1:0] w_lowest;
    logic [4:0]           w_low_idx;

    function automatic logic f_in_range(input logic [15:0] a, input logic [8:0] cnt);
        return ({1'b0, a} < 17'(NUM_REGS)) && (a < {7'd0, cnt});
    endfunction

    assign w_abytes = i_cfg.addr_size_code ? 4'd2 : 4'd1;
    assign w_rbytes = f_reg_bytes(i_cfg.reg_size_code);
    assign w_mask   = f_width_mask(i_cfg.reg_size_code);
    assign w_baddr  = i_cfg.addr_size_code ? i_item.reg_address
                                           : (i_item.reg_address & BYTE_MASK);

    // Isolate the lowest set flag, then encode its position
    assign w_lowest = r_flags & (~r_flags + FLAG_BITS'(1));

    always_comb begin
        w_low_idx = '0;
        for (int i = 0; i < FLAG_BITS; i++) begin
            if (w_lowest[i]) begin
                w_low_idx = w_low_idx | 5'(i);
            end
        end
    end

    always_comb begin
        o_acc   = '0;
        o_acc.status = ST_DONE;
        n_ptr   = r_ptr;
        n_flags = r_flags;
        case (i_item.mode)
            MODE_BUS_WRITE: begin
                if (i_item.byte_count == w_abytes) begin
                    n_ptr = w_baddr;
                end else if (i_item.byte_count == w_abytes + w_rbytes) begin
                    if (!f_in_range(w_baddr, i_cfg.reg_count)) begin
                        o_acc.status = ST_RANGE;
                    end else begin
                        o_acc.ram_we    = 1'b1;
                        o_acc.ram_addr  = w_baddr;
                        o_acc.ram_wdata = i_item.write_data & w_mask;
                        if ({16'd0, w_baddr} < 32'(FLAG_BITS)) begin
                            n_flags = r_flags | (FLAG_BITS'(1) << w_baddr[4:0]);
                        end
                    end
                end else begin
                    o_acc.status = ST_IGNORED;
                end
            end
            MODE_BUS_READ: begin
                o_acc.ram_addr = r_ptr;
                if (f_in_range(r_ptr, i_cfg.reg_count)) begin
                    o_acc.ram_re = 1'b1;
                end else begin
                    o_acc.status = ST_RANGE;
                end
            end
            MODE_LOCAL_READ: begin
                o_acc.ram_addr = i_item.reg_address;
                if (f_in_range(i_item.reg_address, i_cfg.reg_count)) begin
                    o_acc.ram_re = 1'b1;
                end else begin
                    o_acc.status = ST_RANGE;
                end
            end
            MODE_LOCAL_WRITE: begin
                o_acc.ram_addr  = i_item.reg_address;
                o_acc.ram_wdata = i_item.write_data & w_mask;
                if (f_in_range(i_item.reg_address, i_cfg.reg_count)) begin
                    o_acc.ram_we = 1'b1;
                end else begin
                    o_acc.status = ST_RANGE;
                end
            end
            MODE_POP_FLAG: begin
                o_acc.flag_found = |r_flags;
                o_acc.flag_index = w_low_idx;
                n_flags          = r_flags & ~w_lowest;
            end
            default: begin
                o_acc.status = ST_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_flags <= '0;
        end else if (i_commit) begin
            r_ptr   <= n_ptr;
            r_flags <= n_flags;
        end
    end

endmodule

// ===== rtl/core/i2c_target_register_file_unit.sv =====
// Top level of the I2C target register file: pipeline, configuration and store clear.
`timescale 1ns / 1ps
// A result is offered from the stage-two register after leaving stage one.
// Throughput: one transaction per cycle when neither output stall nor clear holds it,
// set by the two-stage path around the registered read port of the register store.
// Reset: synchronous, active low; afterwards the store is cleared one entry per
// cycle across all NUM_REGS entries, during which input is stalled (configuration
// writes are taken as ever).

module i2c_target_register_file_unit #(
    parameter int NUM_REGS  = i2crf_pkg::NUM_REGS_DEF,
    parameter int FLAG_BITS = i2crf_pkg::FLAG_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  i2crf_pkg::t_in_item                   i_in_item,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output i2crf_pkg::t_out_item                  o_out_item,
    input  logic                                  i_cfg_we,
    input  logic [i2crf_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [i2crf_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    import i2crf_pkg::*;

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    // Configuration registers
    t_cfg r_cfg;

    // Stage one: the accepted transaction
    logic     r_s1_valid;
    t_in_item r_s1_item;

    // Stage two: result fields waiting beside the store's read data
    logic     r_s2_valid;
    logic     r_s2_rd_use;
    logic     r_s2_found;
    logic [4:0] r_s2_index;
    t_status  r_s2_status;

    // Clearing pass over the store
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    t_access     w_acc;
    logic        w_adv;
    logic        w_commit;
    logic        w_load;
    logic        w_ram_we;
    logic        w_ram_re;
    logic [AW-1:0] w_ram_addr;
    logic [31:0] w_ram_wdata;
    logic [31:0] w_ram_rdata;

    // Advance the pipeline whenever the result register is free or being taken
    assign w_adv      = !r_s2_valid || !i_out_stall;
    assign w_commit   = r_s1_valid && w_adv;
    assign o_in_stall = r_clr_busy || (r_s1_valid && !w_adv);
    assign w_load     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reg_size_code  <= 2'd0;
            r_cfg.addr_size_code <= 1'b0;
            r_cfg.reg_count      <= REG_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REG_SIZE:  r_cfg.reg_size_code  <= i_cfg_wdata[1:0];
                CFG_ADDR_SIZE: r_cfg.addr_size_code <= i_cfg_wdata[0];
                CFG_REG_COUNT: r_cfg.reg_count      <= i_cfg_wdata;
                default: ;  // drop writes to unknown indexes
            endcase
        end
    end

    // Stage one register: hold while the next stage is stuck
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_load) begin
            r_s1_valid <= 1'b1;
        end else if (w_commit) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s1_item <= i_in_item;
        end
    end

    i2crf_access #(
        .NUM_REGS  (NUM_REGS),
        .FLAG_BITS (FLAG_BITS)
    ) u_access (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_item   (r_s1_item),
        .i_commit (w_commit),
        .o_acc    (w_acc)
    );

    // Clearing pass: zero one entry per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(NUM_REGS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Store port: the clearing pass owns it until done, stage one afterwards
    always_comb begin
        if (r_clr_busy) begin
            w_ram_we    = 1'b1;
            w_ram_re    = 1'b0;
            w_ram_addr  = r_clr_addr;
            w_ram_wdata = '0;
        end else begin
            w_ram_we    = w_commit && w_acc.ram_we;
            w_ram_re    = w_commit && w_acc.ram_re;
            w_ram_addr  = w_acc.ram_addr[AW-1:0];
            w_ram_wdata = w_acc.ram_wdata;
        end
    end

    i2crf_ram #(
        .WIDTH (32),
        .DEPTH (NUM_REGS),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_re    (w_ram_re),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_ram_rdata)
    );

    // Stage two register: the result transaction on offer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_adv) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_s2_rd_use <= w_acc.ram_re;
            r_s2_found  <= w_acc.flag_found;
            r_s2_index  <= w_acc.flag_index;
            r_s2_status <= w_acc.status;
        end
    end

    // Mask the stored entry to the current register width
    assign o_out_valid           = r_s2_valid;
    assign o_out_item.read_data  = r_s2_rd_use ? (w_ram_rdata & f_width_mask(r_cfg.reg_size_code))
                                               : 32'd0;
    assign o_out_item.flag_found = r_s2_found;
    assign o_out_item.flag_index = r_s2_index;
    assign o_out_item.status     = r_s2_status;

    // No transaction enters while the store is being cleared
    a_clear_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> o_in_stall)
        else $error("input accepted during store clear");

    // A failed or ignored access returns no data
    a_status_no_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != ST_DONE)) |-> (o_out_item.read_data == 32'd0))
        else $error("read data on a non-done result");

    // An empty pop reports index zero
    a_empty_pop : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.flag_found) |-> (o_out_item.flag_index == 5'd0))
        else $error("flag index without a found flag");

    // A stuck stage one keeps its transaction
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_adv) |=> (r_s1_valid && $stable(r_s1_item)))
        else $error("stage one lost its transaction");

endmodule
